>>> rtl/u8u16_pkg.sv
// ============================================================================
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 decoder.
// ============================================================================
package u8u16_pkg;

    // Most code units that one input byte can give.
    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam int CP_W = 21;

    localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
    localparam logic [15:0] HI_SURR_TAG = 16'hD800;
    localparam logic [15:0] LO_SURR_TAG = 16'hDC00;

    localparam logic [CP_W-1:0] CP_MIN_LEN3  = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_LEN2  = 21'h000080;
    localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;

    // Sequence lengths, zero meaning no sequence is open.
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    typedef struct packed {
        logic [15:0] unit;
        logic        repl;
    } res_entry_t;

endpackage

>>> rtl/utf8_to_utf16_decoder.sv
// ============================================================================
// utf8_to_utf16_decoder
// Streaming UTF-8 to UTF-16 decoder that replaces malformed input by U+FFFD.
// ============================================================================
// Accepts one byte per cycle while out_ready holds and gives zero to four
// UTF-16 words for it; the words of one byte leave one per cycle, while
// out_ready is high, from a four-entry result buffer, so a byte that yields
// several words holds back the next byte that yields words until its last
// word is taken, while a byte that yields one or none keeps a rate of one
// byte per clock. The result buffer draining at one word per cycle is what
// sets the rate. A byte is registered at the input, then decoded into the
// result buffer. run_end marks the last word of each byte, text_end the last
// word of a byte flagged final_byte; a sequence left open at the end of a
// text gives one extra replacement word and the next text starts fresh.
module utf8_to_utf16_decoder
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_value,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_unit,
    output logic        is_replacement,
    output logic        run_end,
    output logic        text_end
);

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_fin_reg;

    // Decoder state.
    logic [2:0]      el_reg, el_next;
    logic [1:0]      bh_reg, bh_next;
    logic [CP_W-1:0] acc_reg, acc_next;

    // Result buffer.
    res_entry_t           res_buf_reg [MAX_RESULTS];
    logic [RES_CNT_W-1:0] rem_reg;
    logic [RES_IDX_W-1:0] idx_reg;
    logic                 buf_fin_reg;

    // Decode results.
    res_entry_t           res [MAX_RESULTS];
    logic [RES_CNT_W-1:0] cnt;
    logic                 do_lead;
    logic                 is_cont;
    logic [CP_W-1:0]      cp;
    logic [CP_W-1:0]      supp;
    logic                 per_byte;

    logic out_fire;
    logic buf_free;
    logic adv;

    assign out_valid = (rem_reg != '0);
    assign out_fire  = out_valid && out_ready;
    assign buf_free  = (rem_reg == '0) || ((rem_reg == RES_CNT_W'(1)) && out_ready);
    assign adv       = in_valid_reg && ((cnt == '0) || buf_free);
    assign in_ready  = !in_valid_reg || adv;

    assign code_unit      = res_buf_reg[idx_reg].unit;
    assign is_replacement = res_buf_reg[idx_reg].repl;
    assign run_end        = (rem_reg == RES_CNT_W'(1));
    assign text_end       = run_end && buf_fin_reg;

    assign is_cont = (in_byte_reg[7:6] == 2'b10);
    assign cp      = {acc_reg[CP_W-7:0], in_byte_reg[5:0]};
    assign supp    = cp - CP_SUPP_BASE;

    assign per_byte = ((el_reg == SEQ_LEN2) && (cp < CP_MIN_LEN2)) ||
                      ((el_reg == SEQ_LEN3) && (cp < CP_MIN_LEN3)) ||
                      ((el_reg == SEQ_LEN4) &&
                       ((cp < CP_SUPP_BASE) || (cp > CP_MAX)));

    always_comb
    begin
        el_next  = el_reg;
        bh_next  = bh_reg;
        acc_next = acc_reg;
        cnt      = '0;
        do_lead  = 1'b0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i] = '{unit: REPL_UNIT, repl: 1'b1};
        end

        if (el_reg != SEQ_NONE)
        begin
            if (is_cont)
            begin
                if (({1'b0, bh_reg} + 3'd1) >= el_reg)
                begin
                    el_next  = SEQ_NONE;
                    bh_next  = '0;
                    acc_next = '0;
                    if (per_byte)
                    begin
                        for (int i = 0; i < MAX_RESULTS; i++)
                        begin
                            if (3'(i) < el_reg)
                            begin
                                res[cnt[RES_IDX_W-1:0]] = '{unit: REPL_UNIT, repl: 1'b1};
                                cnt = cnt + RES_CNT_W'(1);
                            end
                        end
                    end
                    else if ((el_reg == SEQ_LEN3) && (cp >= CP_SURR_LO) &&
                             (cp <= CP_SURR_HI))
                    begin
                        res[cnt[RES_IDX_W-1:0]] = '{unit: REPL_UNIT, repl: 1'b1};
                        cnt = cnt + RES_CNT_W'(1);
                    end
                    else if (cp >= CP_SUPP_BASE)
                    begin
                        res[cnt[RES_IDX_W-1:0]] =
                            '{unit: HI_SURR_TAG | {6'd0, supp[19:10]}, repl: 1'b0};
                        cnt = cnt + RES_CNT_W'(1);
                        res[cnt[RES_IDX_W-1:0]] =
                            '{unit: LO_SURR_TAG | {6'd0, supp[9:0]}, repl: 1'b0};
                        cnt = cnt + RES_CNT_W'(1);
                    end
                    else
                    begin
                        res[cnt[RES_IDX_W-1:0]] = '{unit: cp[15:0], repl: 1'b0};
                        cnt = cnt + RES_CNT_W'(1);
                    end
                end
                else
                begin
                    acc_next = cp;
                    bh_next  = bh_reg + 2'd1;
                end
            end
            else
            begin
                // The open sequence is broken; the byte starts over as a lead.
                el_next  = SEQ_NONE;
                bh_next  = '0;
                acc_next = '0;
                res[cnt[RES_IDX_W-1:0]] = '{unit: REPL_UNIT, repl: 1'b1};
                cnt = cnt + RES_CNT_W'(1);
                do_lead = 1'b1;
            end
        end
        else
        begin
            do_lead = 1'b1;
        end

        if (do_lead)
        begin
            if (!in_byte_reg[7])
            begin
                res[cnt[RES_IDX_W-1:0]] = '{unit: {8'd0, in_byte_reg}, repl: 1'b0};
                cnt = cnt + RES_CNT_W'(1);
            end
            else if (!in_byte_reg[6] || (in_byte_reg[7:3] == 5'b11111))
            begin
                res[cnt[RES_IDX_W-1:0]] = '{unit: REPL_UNIT, repl: 1'b1};
                cnt = cnt + RES_CNT_W'(1);
            end
            else if (!in_byte_reg[5])
            begin
                el_next  = SEQ_LEN2;
                bh_next  = 2'd1;
                acc_next = {16'd0, in_byte_reg[4:0]};
            end
            else if (!in_byte_reg[4])
            begin
                el_next  = SEQ_LEN3;
                bh_next  = 2'd1;
                acc_next = {17'd0, in_byte_reg[3:0]};
            end
            else
            begin
                el_next  = SEQ_LEN4;
                bh_next  = 2'd1;
                acc_next = {18'd0, in_byte_reg[2:0]};
            end
        end

        if (in_fin_reg)
        begin
            if (el_next != SEQ_NONE)
            begin
                res[cnt[RES_IDX_W-1:0]] = '{unit: REPL_UNIT, repl: 1'b1};
                cnt = cnt + RES_CNT_W'(1);
            end
            el_next  = SEQ_NONE;
            bh_next  = '0;
            acc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            el_reg       <= SEQ_NONE;
            bh_reg       <= '0;
            acc_reg      <= '0;
            rem_reg      <= '0;
            idx_reg      <= '0;
            buf_fin_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end

            if (adv)
            begin
                el_reg  <= el_next;
                bh_reg  <= bh_next;
                acc_reg <= acc_next;
            end

            if (adv && (cnt != '0))
            begin
                rem_reg     <= cnt;
                idx_reg     <= '0;
                buf_fin_reg <= in_fin_reg;
            end
            else if (out_fire)
            begin
                rem_reg <= rem_reg - RES_CNT_W'(1);
                idx_reg <= idx_reg + RES_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= byte_value;
            in_fin_reg  <= final_byte;
        end
        if (adv && (cnt != '0))
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                res_buf_reg[i] <= res[i];
            end
        end
    end

endmodule

>>> tb/utf8_to_utf16_decoder_tb.sv
// ============================================================================
// utf8_to_utf16_decoder_tb
// Self-checking testbench for the UTF-8 to UTF-16 decoder with replacement.
// ============================================================================
// Each byte is sent over the input handshake. A behavioral decoder inside the
// testbench turns every accepted byte into the UTF-16 words that it should
// produce, and a checker compares every word taken from the output with the
// oldest word still waiting. Directed tests cover the field extremes and each
// kind of malformed input. A random stream of mostly well-formed sequences
// with some noise follows. Both handshakes stall at random.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_tb;
    import u8u16_pkg::*;

    localparam logic [7:0] LEAD_CONT  = 8'h80;
    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] LEAD_BAD   = 8'hF8;
    localparam logic [1:0] CONT_TAG   = 2'b10;
    localparam int RANDOM_BYTES       = 185;

    typedef struct packed {
        logic [15:0] unit;
        logic        repl;
        logic        run_last;
        logic        text_last;
    } decoded_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  byte_value;
    logic        final_byte;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] code_unit;
    logic        is_replacement;
    logic        run_end;
    logic        text_end;

    // Decoder state as the testbench sees it.
    logic [2:0]  open_len = SEQ_NONE;
    logic [1:0]  held_cnt = 2'd0;
    logic [20:0] cp_acc   = 21'd0;

    decoded_word_t pending_units[$];
    decoded_word_t oldest_word;
    int            step_count;
    int            bytes_sent     = 0;
    int            mismatch_count = 0;
    logic          quiet;

    utf8_to_utf16_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_value     (byte_value),
        .final_byte     (final_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .code_unit      (code_unit),
        .is_replacement (is_replacement),
        .run_end        (run_end),
        .text_end       (text_end)
    );

    always #2 clk = ~clk;

    initial
    begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Behavioral decoder
    // ------------------------------------------------------------------------
    task automatic add_word(input logic [15:0] unit, input logic repl);
        decoded_word_t w;
        w.unit      = unit;
        w.repl      = repl;
        w.run_last  = 1'b0;
        w.text_last = 1'b0;
        pending_units.push_back(w);
        step_count++;
    endtask

    task automatic clear_sequence();
        open_len = SEQ_NONE;
        held_cnt = 2'd0;
        cp_acc   = 21'd0;
    endtask

    task automatic open_or_emit(input logic [7:0] b);
        logic [2:0] len;
        if (b < LEAD_CONT)
            add_word({8'h00, b}, 1'b0);
        else if (b < LEAD_TWO || b >= LEAD_BAD)
            add_word(REPL_UNIT, 1'b1);
        else
        begin
            if (b < LEAD_THREE)
                len = SEQ_LEN2;
            else if (b < LEAD_FOUR)
                len = SEQ_LEN3;
            else
                len = SEQ_LEN4;
            open_len = len;
            held_cnt = 2'd1;
            cp_acc   = {13'd0, b & (8'hFF >> (len + 3'd1))};
        end
    endtask

    task automatic close_sequence(input logic [2:0] len, input logic [20:0] cp);
        logic [20:0] offs;
        int          i;
        if ((len == SEQ_LEN2 && cp < CP_MIN_LEN2) ||
            (len == SEQ_LEN3 && cp < CP_MIN_LEN3) ||
            (len == SEQ_LEN4 && (cp < CP_SUPP_BASE || cp > CP_MAX)))
        begin
            // Overlong and out-of-range sequences are replaced byte by byte.
            for (i = 0; i < len; i++)
                add_word(REPL_UNIT, 1'b1);
        end
        else if (len == SEQ_LEN3 && cp >= CP_SURR_LO && cp <= CP_SURR_HI)
            add_word(REPL_UNIT, 1'b1);
        else if (cp >= CP_SUPP_BASE)
        begin
            offs = cp - CP_SUPP_BASE;
            add_word(HI_SURR_TAG + {6'd0, offs[19:10]}, 1'b0);
            add_word(LO_SURR_TAG + {6'd0, offs[9:0]}, 1'b0);
        end
        else
            add_word(cp[15:0], 1'b0);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic [20:0]   cp;
        logic [2:0]    len;
        decoded_word_t last;
        step_count = 0;
        if (open_len != SEQ_NONE)
        begin
            if (b[7:6] == CONT_TAG)
            begin
                cp = {cp_acc[14:0], b[5:0]};
                if ({1'b0, held_cnt} + 3'd1 >= open_len)
                begin
                    len = open_len;
                    clear_sequence();
                    close_sequence(len, cp);
                end
                else
                begin
                    cp_acc   = cp;
                    held_cnt = held_cnt + 2'd1;
                end
            end
            else
            begin
                // The open sequence is dropped and this byte starts over.
                clear_sequence();
                add_word(REPL_UNIT, 1'b1);
                open_or_emit(b);
            end
        end
        else
            open_or_emit(b);
        if (fin)
        begin
            if (open_len != SEQ_NONE)
                add_word(REPL_UNIT, 1'b1);
            clear_sequence();
        end
        if (step_count > 0)
        begin
            last           = pending_units.pop_back();
            last.run_last  = 1'b1;
            last.text_last = fin;
            pending_units.push_back(last);
        end
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 99) < 7)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        byte_value <= b;
        final_byte <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_byte(b, fin);
        bytes_sent++;
    endtask

    // Holds the input idle until every outstanding word has been checked.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_units.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_sequence(input logic [20:0] cp, input int n, input int keep,
                                 input logic fin);
        logic [7:0]  b;
        logic [20:0] shifted;
        int          i;
        for (i = 0; i < keep; i++)
        begin
            if (i == 0)
            begin
                case (n)
                    1:       b = {1'b0, cp[6:0]};
                    2:       b = {3'b110, cp[10:6]};
                    3:       b = {4'b1110, cp[15:12]};
                    default: b = {5'b11110, cp[20:18]};
                endcase
            end
            else
            begin
                shifted = cp >> (6 * (n - 1 - i));
                b = {CONT_TAG, shifted[5:0]};
            end
            send_byte(b, fin && (i == keep - 1));
        end
    endtask

    function automatic logic [20:0] random_cp(input int n);
        case (n)
            1:       return 21'($urandom_range(0, 21'h7F));
            2:       return 21'($urandom_range(21'h80, 21'h7FF));
            3:       return 21'($urandom_range(21'h800, 21'hFFFF));
            default: return 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------
    always @(negedge clk)
        out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 7);

    task automatic report_mismatch(input string what, input logic [15:0] expv,
                                   input logic [15:0] actv);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, expv, actv);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_units.size() == 0)
            begin
                $display("%0t: word %h arrived with none expected", $time, code_unit);
                mismatch_count++;
            end
            else
            begin
                oldest_word = pending_units.pop_front();
                if (code_unit !== oldest_word.unit)
                    report_mismatch("code_unit", oldest_word.unit, code_unit);
                if (is_replacement !== oldest_word.repl)
                    report_mismatch("is_replacement", {15'd0, oldest_word.repl},
                                    {15'd0, is_replacement});
                if (run_end !== oldest_word.run_last)
                    report_mismatch("run_end", {15'd0, oldest_word.run_last},
                                    {15'd0, run_end});
                if (text_end !== oldest_word.text_last)
                    report_mismatch("text_end", {15'd0, oldest_word.text_last},
                                    {15'd0, text_end});
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_plain_ascii();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_well_formed();
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // A properly encoded U+FFFD is not a replacement.
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBD, 1'b0);
        // Highest code point, giving the last surrogate pair.
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    task automatic test_stray_lead();
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_broken_sequence();
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
    endtask

    task automatic test_overlong_and_range();
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        // Above the Unicode range: four replacement words for one byte.
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    task automatic test_encoded_surrogate();
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    task automatic test_unfinished_text();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
    endtask

    task automatic test_random_stream();
        int         start;
        int         pick;
        int         n;
        int         k;
        int         i;
        logic       fin;
        logic       drained;
        logic [20:0] cp;
        start   = bytes_sent;
        drained = 1'b0;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            quiet = (bytes_sent - start >= 70) && (bytes_sent - start < 130);
            if (!drained && bytes_sent - start >= 150)
            begin
                drain_results();
                drained = 1'b1;
            end
            fin  = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                n = $urandom_range(1, 4);
                send_sequence(random_cp(n), n, n, fin);
            end
            else if (pick < 68)
            begin
                n = $urandom_range(2, 4);
                case (n)
                    2:       cp = 21'($urandom_range(0, 21'h7F));
                    3:       cp = 21'($urandom_range(0, 21'h7FF));
                    default: cp = 21'($urandom_range(0, 21'hFFFF));
                endcase
                send_sequence(cp, n, n, fin);
            end
            else if (pick < 72)
                send_sequence(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4, fin);
            else if (pick < 76)
                send_sequence(21'($urandom_range(21'hD800, 21'hDFFF)), 3, 3, fin);
            else if (pick < 86)
            begin
                n = $urandom_range(2, 4);
                send_sequence(random_cp(n), n, $urandom_range(1, n - 1), fin);
            end
            else
            begin
                k = $urandom_range(1, 3);
                for (i = 0; i < k; i++)
                    send_byte(8'($urandom_range(0, 255)), fin && (i == k - 1));
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        byte_value = 8'h00;
        final_byte = 1'b0;
        out_ready  = 1'b0;
        quiet      = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_plain_ascii();
        test_well_formed();
        test_stray_lead();
        test_broken_sequence();
        test_overlong_and_range();
        test_encoded_surrogate();
        test_unfinished_text();
        drain_results();
        test_random_stream();
        drain_results();
        repeat (20) @(posedge clk);

        if (mismatch_count == 0 && pending_units.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
